>>> rtl/hplr_pkg.sv
// shared types and constants of the hex packet line receiver
package hplr_pkg;

  localparam int unsigned CNT_W    = 16;
  localparam int unsigned Q_DEPTH  = 4;
  localparam int unsigned Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W  = Q_PTR_W + 1;

  localparam logic [CNT_W-1:0] MAX_LEN_RST = 16'd1280;
  localparam logic [CNT_W-1:0] TIMEOUT_RST = 16'd500;
  localparam logic [CNT_W-1:0] CNT_SAT     = 16'hFFFF;

  // register indexes of the configuration port
  typedef enum logic {
    REG_MAX_LEN = 1'b0,
    REG_TIMEOUT = 1'b1
  } reg_index_t;

  // item opcodes
  typedef enum logic {
    OP_CHAR = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  // result kinds
  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_TIMEOUT = 2'd2
  } kind_t;

  // command passed from the parser to the result sequencer
  typedef struct packed {
    kind_t            kind;
    logic [7:0]       data_byte;
    logic [CNT_W-1:0] byte_count;
    logic             two;        // a completion result follows the data byte
  } hplr_cmd_t;

  // queue status seen by the two sides
  typedef struct packed {
    logic full;
    logic empty;
  } hplr_qstat_t;

endpackage

>>> rtl/hplr_ifs.sv
// item and result channel interfaces
interface hplr_item_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] chr;

  modport source (output valid, output op, output chr, input ready);
  modport sink   (input valid, input op, input chr, output ready);
endinterface

interface hplr_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [15:0] byte_count;
  logic        last;

  modport source (output valid, output kind, output data_byte, output byte_count,
                  output last, input ready);
  modport sink   (input valid, input kind, input data_byte, input byte_count,
                  input last, output ready);
endinterface

>>> rtl/hex_packet_line_receiver.sv
// top level of the hex packet line receiver
//
// usage
//   item channel: one transaction per received character (op 0, chr) or per
//   idle millisecond tick (op 1). lines look like "P:" then optional spaces
//   then pairs of uppercase hex digits, ended by a newline
//   result channel: one transaction per decoded byte (kind 0), per finished
//   line or byte limit (kind 1, with the final count) and per timeout (kind 2)
//   write port: wr_en, wr_index (0 max_len, 1 timeout_ticks), wr_data; only
//   while no transaction is in flight
// timing
//   one item per cycle is taken while the queue has room; the parser settles
//   each item in the cycle it is accepted and queues a command for the result
//   side when the item gives a result; a result passes the command queue and
//   then the output register. an item that hits the byte limit gives two
//   results, the data byte then the completion, from a single queue entry
// stalls and reset
//   a stalled result channel fills the four-entry command queue, after which
//   item ready drops; items that give no result still need a free slot
//   synchronous reset empties the queue, drops result valid, clears the
//   session and loads the register defaults (1280 bytes, 500 ticks)
module hex_packet_line_receiver import hplr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  hplr_item_if.sink        item,
  hplr_result_if.source    result,
  input  logic             wr_en,
  input  logic             wr_index,
  input  logic [CNT_W-1:0] wr_data
);

  logic        push;
  logic        pop;
  hplr_cmd_t   cmd;
  hplr_cmd_t   head;
  hplr_qstat_t qstat;

  // parser side
  hplr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .wr_en    (wr_en),
    .wr_index (reg_index_t'(wr_index)),
    .wr_data  (wr_data),
    .qstat    (qstat),
    .push     (push),
    .cmd      (cmd)
  );

  // decoupling queue
  hplr_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cmd),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  // result side
  hplr_back u_back (
    .clk    (clk),
    .rst    (rst),
    .qstat  (qstat),
    .head   (head),
    .pop    (pop),
    .result (result)
  );

endmodule

>>> rtl/hplr_front.sv
// line parser: accepts items, holds session state, issues commands
module hplr_front import hplr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  hplr_item_if.sink        item,
  input  logic             wr_en,
  input  reg_index_t       wr_index,
  input  logic [CNT_W-1:0] wr_data,
  input  hplr_qstat_t      qstat,
  output logic             push,
  output hplr_cmd_t        cmd
);

  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_F     = 8'h46;

  typedef enum logic [5:0] {
    PH_P     = 6'b000001,
    PH_COLON = 6'b000010,
    PH_FIRST = 6'b000100,
    PH_LOW   = 6'b001000,
    PH_HIGH  = 6'b010000,
    PH_SKIP  = 6'b100000
  } phase_t;

  // bit 4 set when not an uppercase hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'd0;
      if (c >= CH_0 && c <= CH_9) begin
        d = c - CH_0;
        hex_value = {1'b0, d[3:0]};
      end else if (c >= CH_A && c <= CH_F) begin
        d = c - CH_A + 8'd10;
        hex_value = {1'b0, d[3:0]};
      end else begin
        hex_value = 5'b10000;
      end
    end
  endfunction

  logic [CNT_W-1:0] max_len;
  logic [CNT_W-1:0] timeout_ticks;
  phase_t           phase, phase_next;
  logic [3:0]       high_nibble, high_nibble_next;
  logic [CNT_W-1:0] decoded_count, decoded_count_next;
  logic [CNT_W-1:0] idle_ticks, idle_ticks_next;

  logic             accept;
  logic [CNT_W-1:0] ticks_inc;
  logic [CNT_W-1:0] count_inc;
  logic [4:0]       hv;

  assign item.ready = !qstat.full;
  assign accept     = item.valid && item.ready;
  assign ticks_inc  = (idle_ticks != CNT_SAT) ? idle_ticks + 1'b1 : idle_ticks;
  assign count_inc  = decoded_count + 1'b1;
  assign hv         = hex_value(item.chr);

  always_comb begin
    phase_next         = phase;
    high_nibble_next   = high_nibble;
    decoded_count_next = decoded_count;
    idle_ticks_next    = idle_ticks;
    push               = 1'b0;
    cmd.kind           = KIND_DATA;
    cmd.data_byte      = 8'd0;
    cmd.byte_count     = '0;
    cmd.two            = 1'b0;
    if (accept) begin
      if (op_t'(item.op) == OP_TICK) begin
        if (ticks_inc >= timeout_ticks) begin
          push               = 1'b1;
          cmd.kind           = KIND_TIMEOUT;
          phase_next         = PH_P;
          high_nibble_next   = 4'd0;
          decoded_count_next = '0;
          idle_ticks_next    = '0;
        end else begin
          idle_ticks_next = ticks_inc;
        end
      end else if (item.chr == CH_NL) begin
        push               = 1'b1;
        cmd.kind           = KIND_DONE;
        cmd.byte_count     = decoded_count;
        phase_next         = PH_P;
        high_nibble_next   = 4'd0;
        decoded_count_next = '0;
        idle_ticks_next    = '0;
      end else begin
        unique case (phase)
          PH_P:     phase_next = (item.chr == CH_P) ? PH_COLON : PH_SKIP;
          PH_COLON: phase_next = (item.chr == CH_COLON) ? PH_FIRST : PH_SKIP;
          PH_FIRST, PH_HIGH: begin
            if (!(phase == PH_FIRST && item.chr == CH_SPACE)) begin
              if (!hv[4]) begin
                high_nibble_next = hv[3:0];
                phase_next       = PH_LOW;
              end else begin
                phase_next = PH_SKIP;
              end
            end
          end
          PH_LOW: begin
            if (!hv[4]) begin
              push           = 1'b1;
              cmd.kind       = KIND_DATA;
              cmd.data_byte  = {high_nibble, hv[3:0]};
              cmd.byte_count = count_inc;
              if (count_inc >= max_len) begin
                cmd.two            = 1'b1;
                phase_next         = PH_P;
                high_nibble_next   = 4'd0;
                decoded_count_next = '0;
                idle_ticks_next    = '0;
              end else begin
                decoded_count_next = count_inc;
                phase_next         = PH_HIGH;
              end
            end else begin
              phase_next = PH_SKIP;
            end
          end
          PH_SKIP:  phase_next = PH_SKIP;
          default:  phase_next = PH_SKIP;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_P;
      high_nibble   <= 4'd0;
      decoded_count <= '0;
      idle_ticks    <= '0;
      max_len       <= MAX_LEN_RST;
      timeout_ticks <= TIMEOUT_RST;
    end else begin
      phase         <= phase_next;
      high_nibble   <= high_nibble_next;
      decoded_count <= decoded_count_next;
      idle_ticks    <= idle_ticks_next;
      if (wr_en) begin
        case (wr_index)
          REG_MAX_LEN: max_len       <= wr_data;
          REG_TIMEOUT: timeout_ticks <= wr_data;
          default:     max_len       <= max_len;
        endcase
      end
    end
  end

endmodule

>>> rtl/hplr_queue.sv
// small command queue between parser and result sequencer
module hplr_queue import hplr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  hplr_cmd_t   wdata,
  input  logic        pop,
  output hplr_cmd_t   head,
  output hplr_qstat_t qstat
);

  hplr_cmd_t          slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] fill;

  assign head        = slots[rd_ptr];
  assign qstat.full  = (fill == Q_CNT_W'(Q_DEPTH));
  assign qstat.empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> rtl/hplr_back.sv
// result sequencer: expands commands into results behind an output register
module hplr_back import hplr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  hplr_qstat_t qstat,
  input  hplr_cmd_t   head,
  output logic        pop,
  hplr_result_if.source result
);

  logic             out_valid;
  kind_t            out_kind;
  logic [7:0]       out_byte;
  logic [CNT_W-1:0] out_count;
  logic             out_last;
  logic             second_pend;
  logic [CNT_W-1:0] second_count;
  logic             load_ok;

  assign load_ok = !out_valid || result.ready;
  assign pop     = load_ok && !second_pend && !qstat.empty;

  assign result.valid      = out_valid;
  assign result.kind       = out_kind;
  assign result.data_byte  = out_byte;
  assign result.byte_count = out_count;
  assign result.last       = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      second_pend <= 1'b0;
    end else if (load_ok) begin
      if (second_pend) begin
        out_valid   <= 1'b1;
        second_pend <= 1'b0;
      end else if (!qstat.empty) begin
        out_valid   <= 1'b1;
        second_pend <= head.two;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load_ok) begin
      if (second_pend) begin
        out_kind  <= KIND_DONE;
        out_byte  <= 8'd0;
        out_count <= second_count;
        out_last  <= 1'b1;
      end else if (!qstat.empty) begin
        out_kind     <= head.kind;
        out_byte     <= head.data_byte;
        out_count    <= head.byte_count;
        out_last     <= (head.kind != KIND_DATA);
        second_count <= head.byte_count;
      end
    end
  end

endmodule

>>> bench/hplr_line_checker.sv
// passive checker that predicts and compares the results of the hex packet line receiver
module hplr_line_checker import hplr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  hplr_item_if             item,
  hplr_result_if           result,
  input  logic             wr_en,
  input  logic             wr_index,
  input  logic [CNT_W-1:0] wr_data,
  output int               errors,
  output int               outstanding
);

  localparam logic [7:0] CH_P     = "P";
  localparam logic [7:0] CH_COLON = ":";
  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_NINE  = "9";
  localparam logic [7:0] CH_A     = "A";
  localparam logic [7:0] CH_F     = "F";
  localparam int         MAX_PRINTED = 30;

  typedef enum logic [2:0] {
    PH_WANT_P     = 3'd0,
    PH_WANT_COLON = 3'd1,
    PH_LEAD       = 3'd2,
    PH_LOW_DIGIT  = 3'd3,
    PH_HIGH_DIGIT = 3'd4,
    PH_DISCARD    = 3'd5
  } line_phase_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       data_byte;
    logic [CNT_W-1:0] byte_count;
    logic             last;
  } line_result_t;

  logic [CNT_W-1:0] byte_limit;
  logic [CNT_W-1:0] tick_limit;
  line_phase_t      phase;
  logic [3:0]       upper_nibble;
  logic [CNT_W-1:0] bytes_in_line;
  logic [CNT_W-1:0] ticks_in_line;
  line_result_t     due_results[$];

  function automatic void restart_line();
    phase         = PH_WANT_P;
    upper_nibble  = '0;
    bytes_in_line = '0;
    ticks_in_line = '0;
  endfunction

  function automatic void add_result(input kind_t k, input logic [7:0] b,
                                     input logic [CNT_W-1:0] c, input logic l);
    due_results.push_back('{k, b, c, l});
  endfunction

  // bit 4 set when the character is not an uppercase hex digit
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    logic [7:0] d;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
      return {1'b0, d[3:0]};
    end
    if (c >= CH_A && c <= CH_F) begin
      d = c - CH_A + 8'd10;
      return {1'b0, d[3:0]};
    end
    return 5'h10;
  endfunction

  function automatic void decode_item(input op_t op, input logic [7:0] ch);
    logic [4:0] nib;
    if (op == OP_TICK) begin
      if (ticks_in_line != CNT_SAT) ticks_in_line++;
      if (ticks_in_line >= tick_limit) begin
        add_result(KIND_TIMEOUT, 8'h00, '0, 1'b1);
        restart_line();
      end
      return;
    end
    if (ch == CH_NL) begin
      add_result(KIND_DONE, 8'h00, bytes_in_line, 1'b1);
      restart_line();
      return;
    end
    nib = nibble_of(ch);
    case (phase)
      PH_WANT_P: begin
        phase = (ch == CH_P) ? PH_WANT_COLON : PH_DISCARD;
      end
      PH_WANT_COLON: begin
        phase = (ch == CH_COLON) ? PH_LEAD : PH_DISCARD;
      end
      PH_LEAD, PH_HIGH_DIGIT: begin
        // spaces only between the colon and the first digit
        if (!(phase == PH_LEAD && ch == CH_SPACE)) begin
          if (!nib[4]) begin
            upper_nibble = nib[3:0];
            phase        = PH_LOW_DIGIT;
          end else begin
            phase = PH_DISCARD;
          end
        end
      end
      PH_LOW_DIGIT: begin
        if (!nib[4]) begin
          bytes_in_line++;
          add_result(KIND_DATA, {upper_nibble, nib[3:0]}, bytes_in_line, 1'b0);
          phase = PH_HIGH_DIGIT;
          if (bytes_in_line >= byte_limit) begin
            add_result(KIND_DONE, 8'h00, bytes_in_line, 1'b1);
            restart_line();
          end
        end else begin
          phase = PH_DISCARD;
        end
      end
      default: begin
        phase = PH_DISCARD;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    if (errors < MAX_PRINTED) $display("%0t mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_result();
    line_result_t want;
    if (due_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind %0d byte %02h count %0d last %0d",
                                result.kind, result.data_byte, result.byte_count,
                                result.last));
      return;
    end
    want = due_results.pop_front();
    if (result.kind !== want.kind || result.data_byte !== want.data_byte ||
        result.byte_count !== want.byte_count || result.last !== want.last) begin
      report_mismatch($sformatf({"got kind %0d byte %02h count %0d last %0d, ",
                                 "want kind %0d byte %02h count %0d last %0d"},
                                result.kind, result.data_byte, result.byte_count,
                                result.last, want.kind, want.data_byte,
                                want.byte_count, want.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      byte_limit = MAX_LEN_RST;
      tick_limit = TIMEOUT_RST;
      restart_line();
      due_results.delete();
      errors = 0;
    end else begin
      // a result always trails its item, so it is checked before the new item is decoded
      if (result.valid && result.ready) check_result();
      if (wr_en) begin
        if (reg_index_t'(wr_index) == REG_MAX_LEN) byte_limit = wr_data;
        else tick_limit = wr_data;
      end
      if (item.valid && item.ready) decode_item(op_t'(item.op), item.chr);
    end
    outstanding = due_results.size();
  end

endmodule

>>> bench/hex_packet_line_receiver_tb.sv
// testbench top for the hex packet line receiver: stimulus, handshake timing and verdict
module hex_packet_line_receiver_tb;
  import hplr_pkg::*;

  localparam logic [7:0]  CH_P          = "P";
  localparam logic [7:0]  CH_COLON      = ":";
  localparam logic [7:0]  CH_SPACE      = " ";
  localparam logic [7:0]  CH_NL         = 8'h0A;
  localparam logic [7:0]  CH_ZERO       = "0";
  localparam logic [7:0]  CH_A          = "A";
  // margin well past the queue depth before the next register write
  localparam int          SETTLE_CYCLES = 3 * Q_DEPTH + 4;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned PHASE_ITEMS   = 80;

  logic             clk = 1'b0;
  logic             rst;
  logic             wr_en;
  logic             wr_index;
  logic [CNT_W-1:0] wr_data;
  logic             sink_ready = 1'b0;
  logic             steady = 1'b0;    // no idling on either side while set
  logic             draining = 1'b0;  // result side held ready while set
  int               errors;
  int               outstanding;
  int unsigned      sent_items = 0;
  int unsigned      cycle_count = 0;

  hplr_item_if   item_ch ();
  hplr_result_if result_ch ();

  assign result_ch.ready = sink_ready;

  hex_packet_line_receiver uut (
    .clk      (clk),
    .rst      (rst),
    .item     (item_ch),
    .result   (result_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  hplr_line_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .item        (item_ch),
    .result      (result_ch),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  // result side: stalls in roughly a fifth of cycles unless told otherwise
  always @(posedge clk) begin
    if (rst) begin
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= draining || steady || ($urandom_range(99) >= 21);
    end
  end

  // watchdog: a lost result or a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // one item transaction; valid stays high from one transaction to the next
  // unless an idle cycle falls between them
  task automatic send_item(input op_t op, input logic [7:0] ch);
    while (!steady && $urandom_range(99) < 21) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.op    <= op;
    item_ch.chr   <= ch;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    sent_items++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(OP_CHAR, s[i]);
  endtask

  function automatic logic [7:0] random_hex_digit();
    logic [3:0] v;
    v = 4'($urandom_range(15));
    return (v < 4'd10) ? CH_ZERO + 8'(v) : CH_A + 8'(v) - 8'd10;
  endfunction

  // mostly well-formed lines with random content; the rest is noise or lines
  // with one character corrupted. ticks are sprinkled in between characters
  task automatic send_random_line(input int unsigned pairs_max, input int unsigned tick_pct);
    logic [7:0]  text[$];
    int unsigned pick;
    int unsigned pairs;
    int unsigned spot;
    pick = $urandom_range(99);
    if (pick < 4) begin
      // burst of idle ticks, enough to time out the shorter settings
      repeat ($urandom_range(1, 8)) send_item(OP_TICK, 8'($urandom_range(255)));
    end
    if (pick < 12) begin
      repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(255)));
      if ($urandom_range(1)) text.push_back(CH_NL);
    end else begin
      text.push_back(CH_P);
      text.push_back(CH_COLON);
      repeat ($urandom_range(0, 3)) text.push_back(CH_SPACE);
      pairs = $urandom_range(pairs_max);
      repeat (2 * pairs) text.push_back(random_hex_digit());
      text.push_back(CH_NL);
      if (pick < 27) begin
        spot = $urandom_range(text.size() - 1);
        text[spot] = 8'($urandom_range(255));
      end
    end
    foreach (text[n]) begin
      if ($urandom_range(99) < tick_pct) send_item(OP_TICK, 8'($urandom_range(255)));
      send_item(OP_CHAR, text[n]);
    end
  endtask

  // wait for every expected result, then give the command queue time to empty
  task automatic settle();
    item_ch.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
    draining <= 1'b1;
    repeat (SETTLE_CYCLES) @(posedge clk);
    draining <= 1'b0;
  endtask

  // both registers back to back, max_len first and then timeout_ticks
  task automatic load_limits(input logic [CNT_W-1:0] len, input logic [CNT_W-1:0] ticks);
    wr_en    <= 1'b1;
    wr_index <= REG_MAX_LEN;
    wr_data  <= len;
    @(posedge clk);
    wr_index <= REG_TIMEOUT;
    wr_data  <= ticks;
    @(posedge clk);
    wr_en    <= 1'b0;
  endtask

  task automatic run_phase(input logic [CNT_W-1:0] len, input logic [CNT_W-1:0] ticks,
                           input int unsigned pairs_max, input int unsigned tick_pct);
    int unsigned goal;
    load_limits(len, ticks);
    goal = sent_items + PHASE_ITEMS;
    while (sent_items < goal) send_random_line(pairs_max, tick_pct);
    settle();
  endtask

  initial begin
    rst           = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.op    = OP_CHAR;
    item_ch.chr   = 8'h00;
    wr_en         = 1'b0;
    wr_index      = REG_MAX_LEN;
    wr_data       = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed lines at the reset limits
    // a space before the first pair, digits at both ends of each range
    send_text("P: 09AF\n");
    // a space after the first byte is invalid, the byte already out stands
    send_text("P:12 \n");
    // rubbish in place of the start marker, then an empty completion
    send_item(OP_CHAR, 8'hFF);
    send_item(OP_CHAR, CH_NL);
    send_item(OP_CHAR, CH_P);
    send_item(OP_CHAR, 8'h00);
    send_item(OP_CHAR, CH_NL);
    settle();

    // smallest limits: the first tick times out, the first byte ends the line
    load_limits(16'd1, 16'd1);
    send_item(OP_TICK, 8'h00);
    send_text("P:00");
    send_text("P:");
    send_item(OP_TICK, 8'hFF);
    send_item(OP_CHAR, CH_NL);
    settle();

    // random lines under several limit settings
    run_phase(16'd3, 16'd3, 5, 6);
    // long stretch with no idling on either side, largest limits
    steady <= 1'b1;
    run_phase(16'hFFFF, 16'hFFFF, 12, 5);
    steady <= 1'b0;
    run_phase(16'd1, 16'd1, 3, 4);
    run_phase(16'd8, 16'd20, 10, 8);
    run_phase(CNT_W'($urandom_range(1, 16)), CNT_W'($urandom_range(2, 40)), 18, 6);

    @(negedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
